/* hdl/tsd_pkg.sv */
`default_nettype none

package tsd_pkg;

   // block geometry and field widths
   localparam int BLOCK_BYTES = 512;
   localparam int OFF_BITS    = $clog2(BLOCK_BYTES);
   localparam int SIZE_BITS   = 36;
   localparam int DATA_BITS   = 64;
   localparam int USER_BITS   = 4;

   localparam logic [OFF_BITS-1:0] OFF_LAST       = OFF_BITS'(BLOCK_BYTES - 1);
   localparam logic [OFF_BITS-1:0] OFF_SIZE_FIRST = 9'd124;
   localparam logic [OFF_BITS-1:0] OFF_SIZE_LAST  = 9'd135;
   localparam logic [OFF_BITS-1:0] OFF_TYPE       = 9'd156;
   localparam logic [OFF_BITS-1:0] OFF_LINK       = 9'd157;
   localparam logic [OFF_BITS-1:0] OFF_PREFIX     = 9'd345;

   // ascii codes used by the size and type fields
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;

   // byte classification codes
   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_DATA    = 3'd1;
   localparam logic [2:0] KIND_PAD     = 3'd2;
   localparam logic [2:0] KIND_ENDBLK  = 3'd3;
   localparam logic [2:0] KIND_IGNORED = 3'd4;

   // archive framing phase
   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_DATA   = 5'b00010,
      PH_PAD    = 5'b00100,
      PH_ENDBLK = 5'b01000,
      PH_DONE   = 5'b10000
   } phase_type;

   // octal size field scan
   typedef enum logic [2:0] {
      SCAN_SKIP   = 3'b001,
      SCAN_DIGITS = 3'b010,
      SCAN_DONE   = 3'b100
   } scan_type;

   // framing control to the header scanner
   typedef struct packed {
      logic                update;
      logic                clear;
      logic [OFF_BITS-1:0] offset;
   } scan_ctrl_type;

   // header fields seen so far
   typedef struct packed {
      logic                 all_zero;
      logic [SIZE_BITS-1:0] size;
      logic [7:0]           type_code;
      logic                 link_seen;
      logic                 prefix_seen;
   } hdr_info_type;

   // one result item
   typedef struct packed {
      logic [7:0]           out_byte;
      logic [2:0]           byte_kind;
      logic [OFF_BITS-1:0]  block_offset;
      logic                 entry_ready;
      logic [7:0]           entry_type;
      logic [SIZE_BITS-1:0] entry_length;
      logic                 has_link;
      logic                 has_prefix;
      logic                 data_last;
   } result_type;

endpackage

`default_nettype wire

/* hdl/tsd_header_scan.sv */
`default_nettype none

module tsd_header_scan (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     [7:0] in_byte,
   input  tsd_pkg::scan_ctrl_type  scan_ctrl,
   output tsd_pkg::hdr_info_type   hdr_info
);

   logic                          all_zero_ff, all_zero_in;
   logic [tsd_pkg::SIZE_BITS-1:0] size_ff, size_in;
   tsd_pkg::scan_type             scan_ff, scan_in;
   logic [7:0]                    type_ff, type_in;
   logic                          link_ff, link_in;
   logic                          prefix_ff, prefix_in;

   logic in_size_field;
   logic is_blank;
   logic is_octal;
   logic all_zero_now;

   // byte classes for the size field
   always_comb begin
      in_size_field = (scan_ctrl.offset >= tsd_pkg::OFF_SIZE_FIRST) &&
                      (scan_ctrl.offset <= tsd_pkg::OFF_SIZE_LAST);
      is_blank      = (in_byte == tsd_pkg::CHAR_SPACE) || (in_byte == tsd_pkg::CHAR_NUL);
      is_octal      = (in_byte >= tsd_pkg::CHAR_ZERO) && (in_byte <= tsd_pkg::CHAR_SEVEN);
      all_zero_now  = all_zero_ff && (in_byte == tsd_pkg::CHAR_NUL);
   end

   // field capture, cleared after the last header byte
   always_comb begin
      all_zero_in = all_zero_ff;
      size_in     = size_ff;
      scan_in     = scan_ff;
      type_in     = type_ff;
      link_in     = link_ff;
      prefix_in   = prefix_ff;
      if (scan_ctrl.update) begin
         if (scan_ctrl.clear) begin
            all_zero_in = 1'b1;
            size_in     = '0;
            scan_in     = tsd_pkg::SCAN_SKIP;
            type_in     = '0;
            link_in     = 1'b0;
            prefix_in   = 1'b0;
         end else begin
            all_zero_in = all_zero_now;
            if (in_size_field) begin
               if ((scan_ff == tsd_pkg::SCAN_SKIP) && is_blank) begin
                  scan_in = scan_ff;
               end else if ((scan_ff != tsd_pkg::SCAN_DONE) && is_octal) begin
                  scan_in = tsd_pkg::SCAN_DIGITS;
                  size_in = {size_ff[tsd_pkg::SIZE_BITS-4:0], in_byte[2:0]};
               end else begin
                  scan_in = tsd_pkg::SCAN_DONE;
               end
            end
            if (scan_ctrl.offset == tsd_pkg::OFF_TYPE) begin
               type_in = (in_byte == tsd_pkg::CHAR_NUL) ? tsd_pkg::CHAR_ZERO : in_byte;
            end
            if (scan_ctrl.offset == tsd_pkg::OFF_LINK) begin
               link_in = (in_byte != tsd_pkg::CHAR_NUL);
            end
            if (scan_ctrl.offset == tsd_pkg::OFF_PREFIX) begin
               prefix_in = (in_byte != tsd_pkg::CHAR_NUL);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         all_zero_ff <= 1'b1;
         size_ff     <= '0;
         scan_ff     <= tsd_pkg::SCAN_SKIP;
         type_ff     <= '0;
         link_ff     <= 1'b0;
         prefix_ff   <= 1'b0;
      end else begin
         all_zero_ff <= all_zero_in;
         size_ff     <= size_in;
         scan_ff     <= scan_in;
         type_ff     <= type_in;
         link_ff     <= link_in;
         prefix_ff   <= prefix_in;
      end
   end

   // all_zero includes the current byte so the last header byte counts
   always_comb begin
      hdr_info.all_zero    = all_zero_now;
      hdr_info.size        = size_ff;
      hdr_info.type_code   = type_ff;
      hdr_info.link_seen   = link_ff;
      hdr_info.prefix_seen = prefix_ff;
   end

endmodule

`default_nettype wire

/* hdl/tsd_block_ctrl.sv */
`default_nettype none

module tsd_block_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     step,
   input  wire                     [7:0] in_byte,
   input  tsd_pkg::hdr_info_type   hdr_info,
   output tsd_pkg::scan_ctrl_type  scan_ctrl,
   output tsd_pkg::result_type     result
);

   tsd_pkg::phase_type            phase_ff, phase_in;
   logic [tsd_pkg::OFF_BITS-1:0]  offset_ff, offset_in;
   logic [tsd_pkg::SIZE_BITS-1:0] left_ff, left_in;

   logic last_in_block;
   logic left_final;

   always_comb begin
      last_in_block = (offset_ff == tsd_pkg::OFF_LAST);
      left_final    = (left_ff[tsd_pkg::SIZE_BITS-1:1] == '0);
   end

   // header scanner runs only in the header phase
   always_comb begin
      scan_ctrl.update = step && (phase_ff == tsd_pkg::PH_HEADER);
      scan_ctrl.clear  = last_in_block;
      scan_ctrl.offset = offset_ff;
   end

   // phase sequencing and result fields
   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      result   = '0;
      result.out_byte     = in_byte;
      result.block_offset = offset_ff;
      unique case (phase_ff)
         tsd_pkg::PH_HEADER: begin
            result.byte_kind = tsd_pkg::KIND_HEADER;
            if (last_in_block) begin
               if (hdr_info.all_zero) begin
                  phase_in = tsd_pkg::PH_ENDBLK;
               end else begin
                  result.entry_ready  = 1'b1;
                  result.entry_type   = hdr_info.type_code;
                  result.entry_length = hdr_info.size;
                  result.has_link     = hdr_info.link_seen;
                  result.has_prefix   = hdr_info.prefix_seen;
                  left_in             = hdr_info.size;
                  phase_in = (hdr_info.size != '0) ? tsd_pkg::PH_DATA : tsd_pkg::PH_HEADER;
               end
            end
         end
         tsd_pkg::PH_DATA: begin
            result.byte_kind = tsd_pkg::KIND_DATA;
            if (left_final) begin
               left_in          = '0;
               result.data_last = 1'b1;
               phase_in = last_in_block ? tsd_pkg::PH_HEADER : tsd_pkg::PH_PAD;
            end else begin
               left_in = left_ff - tsd_pkg::SIZE_BITS'(1);
            end
         end
         tsd_pkg::PH_PAD: begin
            result.byte_kind = tsd_pkg::KIND_PAD;
            if (last_in_block) begin
               phase_in = tsd_pkg::PH_HEADER;
            end
         end
         tsd_pkg::PH_ENDBLK: begin
            result.byte_kind = tsd_pkg::KIND_ENDBLK;
            if (last_in_block) begin
               phase_in = tsd_pkg::PH_DONE;
            end
         end
         default: begin
            result.byte_kind = tsd_pkg::KIND_IGNORED;
         end
      endcase
      offset_in = last_in_block ? '0 : (offset_ff + tsd_pkg::OFF_BITS'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= tsd_pkg::PH_HEADER;
         offset_ff <= '0;
         left_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         left_ff   <= left_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/tar_stream_deframer.sv */
// an accepted byte is held in the input register, and its result then in the result register
// throughput: one byte per cycle while rsp is not stalled, the framing state updates once per byte
// input register and result register each hold one item, so while a result
// stalls one more byte is still taken into the input register
// reset (synchronous, active high) empties both registers and returns the
// framer to the header phase at block offset zero
`default_nettype none

module tar_stream_deframer (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [7:0]                       req_tdata,  // in_byte
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // out_byte, block_offset, entry_type, entry_length, has_link, has_prefix, zero pad
   output logic [tsd_pkg::DATA_BITS-1:0]    rsp_tdata,
   output logic [tsd_pkg::USER_BITS-1:0]    rsp_tuser,  // byte_kind, entry_ready
   output logic                             rsp_tlast   // data_last
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                rsp_valid_ff;
   tsd_pkg::result_type rsp_ff;

   logic                   out_free;
   logic                   step;
   tsd_pkg::scan_ctrl_type scan_ctrl;
   tsd_pkg::hdr_info_type  hdr_info;
   tsd_pkg::result_type    result;

   // handshake
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      step       = in_valid_ff && out_free;
      req_tready = !in_valid_ff || out_free;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   tsd_header_scan u_header_scan (
      .clock     (clock),
      .reset     (reset),
      .in_byte   (in_byte_ff),
      .scan_ctrl (scan_ctrl),
      .hdr_info  (hdr_info)
   );

   tsd_block_ctrl u_block_ctrl (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_byte   (in_byte_ff),
      .hdr_info  (hdr_info),
      .scan_ctrl (scan_ctrl),
      .result    (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   // port packing
   always_comb begin
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {1'b0, rsp_ff.has_prefix, rsp_ff.has_link, rsp_ff.entry_length,
                    rsp_ff.entry_type, rsp_ff.block_offset, rsp_ff.out_byte};
      rsp_tuser  = {rsp_ff.entry_ready, rsp_ff.byte_kind};
      rsp_tlast  = rsp_ff.data_last;
   end

endmodule

`default_nettype wire

/* hdl/tsd_checker.sv */
`default_nettype none

module tsd_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           rsp_tvalid,
   input wire                           rsp_tready,
   input wire [tsd_pkg::DATA_BITS-1:0]  rsp_tdata,
   input wire [tsd_pkg::USER_BITS-1:0]  rsp_tuser,
   input wire                           rsp_tlast
);

   // nothing leaves right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
      && $stable(rsp_tlast))
      else $error("stalled rsp item changed");

   // an entry report sits on the last byte of a header block
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |->
      rsp_tuser[2:0] == tsd_pkg::KIND_HEADER && rsp_tdata[16:8] == tsd_pkg::OFF_LAST)
      else $error("entry report off the last header byte");

   // last data byte is a data byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[2:0] == tsd_pkg::KIND_DATA)
      else $error("data last on non-data byte");

   // entry fields are zero without a report
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[3] |-> rsp_tdata[62:17] == '0)
      else $error("entry fields set without entry report");

endmodule

bind tar_stream_deframer tsd_checker u_tsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

/* bench/tb_tar_stream_deframer.sv */
`timescale 1ns / 100ps

module tb_tar_stream_deframer;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PRINT_LIMIT = 40;
   localparam int ITEM_COUNT  = 650;

   // ways of writing the octal size field
   localparam int SZ_PLAIN  = 0;  // eleven digits and a terminator
   localparam int SZ_PADDED = 1;  // leading blanks, short digits, terminator, junk
   localparam int SZ_FULL   = 2;  // twelve digits, no terminator
   localparam int SZ_NONE   = 3;  // blanks only or junk first, no digits

   // predicts the classification of every archive byte and checks the results
   class deframe_scoreboard;
      tsd_pkg::phase_type            phase;
      logic [tsd_pkg::OFF_BITS-1:0]  offset;
      logic [tsd_pkg::SIZE_BITS-1:0] bytes_left;
      logic [tsd_pkg::SIZE_BITS-1:0] size_acc;
      tsd_pkg::scan_type             scan;
      logic                          all_zero;
      logic [7:0]                    type_code;
      logic                          link_seen;
      logic                          prefix_seen;
      tsd_pkg::result_type           pending_bytes[$];
      int                            errors;
      int                            noted;
      int                            checked;
      int                            entries;
      int                            data_ends;

      function new();
         phase      = tsd_pkg::PH_HEADER;
         offset     = '0;
         bytes_left = '0;
         clear_header();
         errors     = 0;
         noted      = 0;
         checked    = 0;
         entries    = 0;
         data_ends  = 0;
      endfunction

      function void clear_header();
         size_acc    = '0;
         scan        = tsd_pkg::SCAN_SKIP;
         all_zero    = 1'b1;
         type_code   = 8'h00;
         link_seen   = 1'b0;
         prefix_seen = 1'b0;
      endfunction

      // advance the framing state by one accepted byte and queue its result
      function void note_byte(input logic [7:0] b);
         tsd_pkg::result_type want;
         logic                last_in_block;
         want               = '0;
         want.out_byte      = b;
         want.block_offset  = offset;
         last_in_block      = (offset == tsd_pkg::OFF_LAST);
         case (phase)
            tsd_pkg::PH_HEADER: begin
               want.byte_kind = tsd_pkg::KIND_HEADER;
               if (b != tsd_pkg::CHAR_NUL) all_zero = 1'b0;
               // octal size field
               if (offset >= tsd_pkg::OFF_SIZE_FIRST && offset <= tsd_pkg::OFF_SIZE_LAST) begin
                  if (scan == tsd_pkg::SCAN_SKIP &&
                      (b == tsd_pkg::CHAR_SPACE || b == tsd_pkg::CHAR_NUL)) begin
                     // leading blank, keep skipping
                  end else if (scan != tsd_pkg::SCAN_DONE && b >= tsd_pkg::CHAR_ZERO &&
                               b <= tsd_pkg::CHAR_SEVEN) begin
                     scan     = tsd_pkg::SCAN_DIGITS;
                     size_acc = (size_acc << 3) |
                                tsd_pkg::SIZE_BITS'(b - tsd_pkg::CHAR_ZERO);
                  end else begin
                     scan = tsd_pkg::SCAN_DONE;
                  end
               end
               if (offset == tsd_pkg::OFF_TYPE)
                  type_code = (b == tsd_pkg::CHAR_NUL) ? tsd_pkg::CHAR_ZERO : b;
               if (offset == tsd_pkg::OFF_LINK) link_seen = (b != tsd_pkg::CHAR_NUL);
               if (offset == tsd_pkg::OFF_PREFIX) prefix_seen = (b != tsd_pkg::CHAR_NUL);
               // end of the header block
               if (last_in_block) begin
                  if (all_zero) begin
                     phase = tsd_pkg::PH_ENDBLK;
                  end else begin
                     want.entry_ready  = 1'b1;
                     want.entry_type   = type_code;
                     want.entry_length = size_acc;
                     want.has_link     = link_seen;
                     want.has_prefix   = prefix_seen;
                     bytes_left        = size_acc;
                     phase = (size_acc != 0) ? tsd_pkg::PH_DATA : tsd_pkg::PH_HEADER;
                     entries++;
                  end
                  clear_header();
               end
            end
            tsd_pkg::PH_DATA: begin
               want.byte_kind = tsd_pkg::KIND_DATA;
               if (bytes_left <= 1) begin
                  bytes_left     = '0;
                  want.data_last = 1'b1;
                  phase          = last_in_block ? tsd_pkg::PH_HEADER : tsd_pkg::PH_PAD;
                  data_ends++;
               end else begin
                  bytes_left = bytes_left - 1'b1;
               end
            end
            tsd_pkg::PH_PAD: begin
               want.byte_kind = tsd_pkg::KIND_PAD;
               if (last_in_block) phase = tsd_pkg::PH_HEADER;
            end
            tsd_pkg::PH_ENDBLK: begin
               want.byte_kind = tsd_pkg::KIND_ENDBLK;
               if (last_in_block) phase = tsd_pkg::PH_DONE;
            end
            default: begin
               want.byte_kind = tsd_pkg::KIND_IGNORED;
            end
         endcase
         offset = last_in_block ? '0 : offset + 1'b1;
         pending_bytes.push_back(want);
         noted++;
      endfunction

      task report(input string field, input logic [63:0] got, input logic [63:0] want);
         errors++;
         if (errors <= PRINT_LIMIT)
            $display("result %0d: %s is 0x%0h, predicted 0x%0h", checked, field, got, want);
      endtask

      // compare one accepted result with the oldest prediction
      task check_byte(input logic [tsd_pkg::DATA_BITS-1:0] tdata,
                      input logic [tsd_pkg::USER_BITS-1:0] tuser, input logic tlast);
         tsd_pkg::result_type want;
         if (pending_bytes.size() == 0) begin
            report("unpredicted result, tdata", tdata, 64'(0));
            return;
         end
         want = pending_bytes.pop_front();
         if (tdata[7:0] !== want.out_byte)
            report("out_byte", 64'(tdata[7:0]), 64'(want.out_byte));
         if (tdata[16:8] !== want.block_offset)
            report("block_offset", 64'(tdata[16:8]), 64'(want.block_offset));
         if (tdata[24:17] !== want.entry_type)
            report("entry_type", 64'(tdata[24:17]), 64'(want.entry_type));
         if (tdata[60:25] !== want.entry_length)
            report("entry_length", 64'(tdata[60:25]), 64'(want.entry_length));
         if (tdata[61] !== want.has_link)
            report("has_link", 64'(tdata[61]), 64'(want.has_link));
         if (tdata[62] !== want.has_prefix)
            report("has_prefix", 64'(tdata[62]), 64'(want.has_prefix));
         if (tuser[2:0] !== want.byte_kind)
            report("byte_kind", 64'(tuser[2:0]), 64'(want.byte_kind));
         if (tuser[3] !== want.entry_ready)
            report("entry_ready", 64'(tuser[3]), 64'(want.entry_ready));
         if (tlast !== want.data_last)
            report("data_last", 64'(tlast), 64'(want.data_last));
         checked++;
      endtask
   endclass

   logic                          clock;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata  = 8'h00;  // in_byte
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   // out_byte, block_offset, entry_type, entry_length, has_link, has_prefix, zero pad
   logic [tsd_pkg::DATA_BITS-1:0] rsp_tdata;
   logic [tsd_pkg::USER_BITS-1:0] rsp_tuser;          // byte_kind, entry_ready
   logic                          rsp_tlast;          // data_last

   deframe_scoreboard sb = new();
   int                send_idle_pct = 11;
   int                recv_idle_pct = 65;
   int                cycle_count   = 0;
   logic [7:0]        hdr_buf [0:tsd_pkg::BLOCK_BYTES-1];

   tar_stream_deframer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver with random stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_byte(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // offer one byte, with random gaps before it, and wait for its handshake
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b);
   endtask

   // any byte that is not an octal digit, blanks optional
   function automatic logic [7:0] pick_non_octal(input bit allow_blank);
      logic [7:0] b;
      do begin
         b = 8'($urandom);
      end while ((b >= tsd_pkg::CHAR_ZERO && b <= tsd_pkg::CHAR_SEVEN) ||
                 (!allow_blank && (b == tsd_pkg::CHAR_NUL || b == tsd_pkg::CHAR_SPACE)));
      return b;
   endfunction

   task automatic put_octal(input int start, input int ndig,
                            input logic [tsd_pkg::SIZE_BITS-1:0] v);
      int i;
      for (i = 0; i < ndig; i++)
         hdr_buf[start+i] = tsd_pkg::CHAR_ZERO + 8'((v >> (3 * (ndig - 1 - i))) & 7);
   endtask

   // fill the header block: dense random bytes or a mostly empty block
   task automatic build_header(input bit dense, input logic [tsd_pkg::SIZE_BITS-1:0] size_val,
                               input int style, input logic [7:0] type_byte,
                               input logic [7:0] link_byte, input logic [7:0] prefix_byte);
      int i;
      int nd;
      int lead;
      int pos;
      for (i = 0; i < tsd_pkg::BLOCK_BYTES; i++)
         hdr_buf[i] = dense ? 8'($urandom) :
                      (($urandom_range(7) == 0) ? 8'($urandom) : tsd_pkg::CHAR_NUL);
      hdr_buf[0] = 8'h61 + 8'($urandom_range(25));
      for (i = tsd_pkg::OFF_SIZE_FIRST; i <= tsd_pkg::OFF_SIZE_LAST; i++)
         hdr_buf[i] = tsd_pkg::CHAR_NUL;
      nd = 1;
      while (nd < 12 && (size_val >> (3 * nd)) != 0) nd++;
      case (style)
         SZ_PLAIN: begin
            put_octal(tsd_pkg::OFF_SIZE_FIRST, 11, size_val);
            hdr_buf[tsd_pkg::OFF_SIZE_LAST] =
               $urandom_range(1) ? tsd_pkg::CHAR_SPACE : tsd_pkg::CHAR_NUL;
         end
         SZ_PADDED: begin
            lead = $urandom_range(11 - nd);
            for (i = 0; i < lead; i++)
               hdr_buf[tsd_pkg::OFF_SIZE_FIRST+i] =
                  $urandom_range(1) ? tsd_pkg::CHAR_SPACE : tsd_pkg::CHAR_NUL;
            put_octal(tsd_pkg::OFF_SIZE_FIRST + lead, nd, size_val);
            pos = tsd_pkg::OFF_SIZE_FIRST + lead + nd;
            hdr_buf[pos] = pick_non_octal(1'b1);
            // anything after the terminator is ignored, digits included
            for (i = pos + 1; i <= tsd_pkg::OFF_SIZE_LAST; i++) hdr_buf[i] = 8'($urandom);
         end
         SZ_FULL: begin
            put_octal(tsd_pkg::OFF_SIZE_FIRST, 12, size_val);
         end
         default: begin
            if ($urandom_range(1)) begin
               for (i = tsd_pkg::OFF_SIZE_FIRST; i <= tsd_pkg::OFF_SIZE_LAST; i++)
                  hdr_buf[i] = $urandom_range(1) ? tsd_pkg::CHAR_SPACE : tsd_pkg::CHAR_NUL;
            end else begin
               hdr_buf[tsd_pkg::OFF_SIZE_FIRST] = pick_non_octal(1'b0);
               for (i = tsd_pkg::OFF_SIZE_FIRST + 1; i <= tsd_pkg::OFF_SIZE_LAST; i++)
                  hdr_buf[i] = 8'($urandom);
            end
         end
      endcase
      hdr_buf[tsd_pkg::OFF_TYPE]   = type_byte;
      hdr_buf[tsd_pkg::OFF_LINK]   = link_byte;
      hdr_buf[tsd_pkg::OFF_PREFIX] = prefix_byte;
   endtask

   initial begin
      int                            i;
      logic [tsd_pkg::SIZE_BITS-1:0] size_val;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // one entry: padded size field, data bytes, then padding
      size_val = tsd_pkg::SIZE_BITS'($urandom_range(40, 120));
      build_header(1'b1, size_val, SZ_PADDED, tsd_pkg::CHAR_NUL, 8'h6c, 8'h00);
      for (i = 0; i < ITEM_COUNT; i++) begin
         // swapped idling, then none
         if (i == ITEM_COUNT / 3) begin
            send_idle_pct = 65;
            recv_idle_pct = 11;
         end
         if (i == 2 * ITEM_COUNT / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (i < tsd_pkg::BLOCK_BYTES) begin
            send_byte(hdr_buf[i]);
         end else begin
            send_byte(8'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      // drain
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.pending_bytes.size() != 0)
         sb.report("results missing, count", 64'(sb.pending_bytes.size()), 64'(0));

      $display("covered %0d archive bytes with %0d entries reported and %0d data ends",
               sb.noted, sb.entries, sb.data_ends);
      $display("header parse, data and padding under stalls; %0d results compared, %0d errors",
               sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* tar_stream_deframer.f */
hdl/tsd_pkg.sv
hdl/tsd_header_scan.sv
hdl/tsd_block_ctrl.sv
hdl/tar_stream_deframer.sv
hdl/tsd_checker.sv
bench/tb_tar_stream_deframer.sv
